// File: hw/rtl/tasc_pkg.sv
// Shared types and constants for the transactional abort statistics block.
package tasc_pkg;

	localparam int NUM_COUNTERS = 15;
	localparam int CNT_W        = 32;
	localparam int SEL_W        = 4;

	// RTM status word layout
	localparam int BIT_EXPLICIT = 0;
	localparam int BIT_RETRY    = 1;
	localparam int BIT_CONFLICT = 2;
	localparam int BIT_CAPACITY = 3;
	localparam int BIT_DEBUG    = 4;
	localparam int BIT_NESTED   = 5;
	localparam int CODE_LSB     = 24;

	// counter slots within one entry's row
	localparam logic [SEL_W-1:0] CNT_TOTAL        = 4'd0;
	localparam logic [SEL_W-1:0] CNT_EXPLICIT     = 4'd1;
	localparam logic [SEL_W-1:0] CNT_LOCK_TAKEN   = 4'd2;
	localparam logic [SEL_W-1:0] CNT_RETRY        = 4'd3;
	localparam logic [SEL_W-1:0] CNT_RETRY_CONFL  = 4'd4;
	localparam logic [SEL_W-1:0] CNT_RETRY_CAPAC  = 4'd5;
	localparam logic [SEL_W-1:0] CNT_CONFLICT     = 4'd6;
	localparam logic [SEL_W-1:0] CNT_CAPACITY     = 4'd7;
	localparam logic [SEL_W-1:0] CNT_DEBUG        = 4'd8;
	localparam logic [SEL_W-1:0] CNT_NESTED       = 4'd9;
	localparam logic [SEL_W-1:0] CNT_ZERO_STATUS  = 4'd10;
	localparam logic [SEL_W-1:0] CNT_COMMITS      = 4'd11;
	localparam logic [SEL_W-1:0] CNT_FALLBACKS    = 4'd12;
	localparam logic [SEL_W-1:0] CNT_COMMIT_RSUM  = 4'd13;
	localparam logic [SEL_W-1:0] CNT_FALLBK_RSUM  = 4'd14;

	localparam logic [7:0] LOCK_CODE_RESET = 8'd255;

	typedef enum logic [1:0] {
		OP_ABORT,
		OP_COMMIT,
		OP_FALLBACK,
		OP_READ
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE
	} state_t;

	typedef logic [NUM_COUNTERS-1:0][CNT_W-1:0] row_t;

	typedef struct packed {
		op_t              op;
		logic [31:0]      status;
		logic [15:0]      retry;
		logic [SEL_W-1:0] sel;
		logic             in_range;
	} evt_t;

endpackage

// File: hw/rtl/tasc_counter_ram.sv
// Counter memory: one row of counters per thread and transaction id, registered read.
module tasc_counter_ram #(
	parameter int DEPTH  = 128,
	parameter int ADDR_W = 7
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output tasc_pkg::row_t    rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  tasc_pkg::row_t    wr_data
);
	import tasc_pkg::*;

	row_t mem [DEPTH];
	row_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: hw/rtl/tasc_row_update.sv
// Decodes one event against the entry's row: new row, read-back value and error flag.
module tasc_row_update (
	input  tasc_pkg::evt_t  evt,
	input  logic [7:0]      lock_code,
	input  tasc_pkg::row_t  row_in,
	output tasc_pkg::row_t  row_out,
	output logic            row_wr,
	output logic [31:0]     read_value,
	output logic            status_error
);
	import tasc_pkg::*;

	logic [31:0] st;
	logic [CNT_W-1:0] retry_ext;

	assign st        = evt.status;
	assign retry_ext = CNT_W'(evt.retry);

	always_comb begin
		row_out      = row_in;
		row_wr       = 1'b0;
		read_value   = '0;
		status_error = 1'b0;
		unique case (evt.op)
			OP_ABORT: begin
				status_error = st[BIT_RETRY] & (st[BIT_DEBUG] | st[BIT_NESTED]);
				row_wr = evt.in_range;
				row_out[CNT_TOTAL] = row_in[CNT_TOTAL] + 32'd1;
				if (st[BIT_EXPLICIT]) begin
					row_out[CNT_EXPLICIT] = row_in[CNT_EXPLICIT] + 32'd1;
					if (st[CODE_LSB +: 8] == lock_code) begin
						row_out[CNT_LOCK_TAKEN] = row_in[CNT_LOCK_TAKEN] + 32'd1;
					end
				end
				if (st[BIT_RETRY]) begin
					row_out[CNT_RETRY] = row_in[CNT_RETRY] + 32'd1;
					if (st[BIT_CONFLICT]) begin
						row_out[CNT_RETRY_CONFL] = row_in[CNT_RETRY_CONFL] + 32'd1;
					end
					if (st[BIT_CAPACITY]) begin
						row_out[CNT_RETRY_CAPAC] = row_in[CNT_RETRY_CAPAC] + 32'd1;
					end
				end
				if (st[BIT_CONFLICT]) begin
					row_out[CNT_CONFLICT] = row_in[CNT_CONFLICT] + 32'd1;
				end
				if (st[BIT_CAPACITY]) begin
					row_out[CNT_CAPACITY] = row_in[CNT_CAPACITY] + 32'd1;
				end
				if (st[BIT_DEBUG]) begin
					row_out[CNT_DEBUG] = row_in[CNT_DEBUG] + 32'd1;
				end
				if (st[BIT_NESTED]) begin
					row_out[CNT_NESTED] = row_in[CNT_NESTED] + 32'd1;
				end
				if (st == 32'd0) begin
					row_out[CNT_ZERO_STATUS] = row_in[CNT_ZERO_STATUS] + 32'd1;
				end
			end
			OP_COMMIT: begin
				row_wr = evt.in_range;
				row_out[CNT_COMMITS]     = row_in[CNT_COMMITS] + 32'd1;
				row_out[CNT_COMMIT_RSUM] = row_in[CNT_COMMIT_RSUM] + retry_ext;
			end
			OP_FALLBACK: begin
				row_wr = evt.in_range;
				row_out[CNT_FALLBACKS]   = row_in[CNT_FALLBACKS] + 32'd1;
				row_out[CNT_FALLBK_RSUM] = row_in[CNT_FALLBK_RSUM] + retry_ext;
			end
			OP_READ: begin
				// select 15 has no counter behind it
				if (evt.in_range && (evt.sel != 4'hF)) begin
					read_value = row_in[evt.sel];
				end
			end
			default: begin
				row_wr = 1'b0;
			end
		endcase
	end

endmodule

// File: hw/rtl/tx_abort_stats_counters_core.sv
// Top level: transactional abort statistics table with counter memory and word handshakes.
// For each accepted word the entry's row of fifteen counters is read from the counter
// memory, then updated and written back when the result is loaded into the output register,
// which waits while a stalled result still holds that register. A new word is taken only
// once the previous one has been completed, so back-to-back events on the same entry always
// see the updated row.
// After reset the memory is cleared one row a cycle, NUM_THREADS * NUM_TX_IDS rows
// (128 by default), with in_stall held high; the lock-taken code may be written meanwhile.
module tx_abort_stats_counters_core #(
	parameter int NUM_THREADS = 8,
	parameter int NUM_TX_IDS  = 16,
	localparam int TH_W = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1,
	localparam int TX_W = (NUM_TX_IDS > 1) ? $clog2(NUM_TX_IDS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [7:0]       cfg_wr_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       opcode,
	input  logic [TH_W-1:0]  thread_id,
	input  logic [TX_W-1:0]  transaction_id,
	input  logic [31:0]      abort_status,
	input  logic [15:0]      retry_count,
	input  logic [3:0]       counter_select,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [31:0]      read_value,
	output logic             status_error
);
	import tasc_pkg::*;

	localparam int NUM_ROWS = NUM_THREADS * NUM_TX_IDS;
	localparam int ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

	state_t            state_q, state_d;
	logic [ROW_W-1:0]  clr_addr_q;
	logic [ROW_W-1:0]  addr_q;
	evt_t              evt_q;
	logic [7:0]        lock_code_q;
	logic              out_valid_q;
	logic [31:0]       read_value_q;
	logic              status_error_q;

	logic              in_acc;
	logic              done;
	logic              in_range;
	logic [ROW_W-1:0]  in_addr;
	row_t              rd_row;
	row_t              upd_row;
	logic              upd_wr;
	logic [31:0]       upd_value;
	logic              upd_err;
	logic              mem_wr_en;
	logic [ROW_W-1:0]  mem_wr_addr;
	row_t              mem_wr_data;
	logic              clr_last;

	assign in_range = ({1'b0, thread_id} < (TH_W + 1)'(NUM_THREADS)) &&
	                  ({1'b0, transaction_id} < (TX_W + 1)'(NUM_TX_IDS));
	assign in_addr  = ROW_W'(int'(thread_id) * NUM_TX_IDS + int'(transaction_id));

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	// result can leave for the output register once it is free or being drained
	assign done     = (state_q == ST_UPDATE) && (!out_valid_q || !out_stall);
	assign clr_last = (clr_addr_q == ROW_W'(NUM_ROWS - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_addr_q <= clr_addr_q + ROW_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_code_q <= LOCK_CODE_RESET;
		end else if (cfg_wr_en) begin
			lock_code_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_q          <= in_addr;
			evt_q.op        <= op_t'(opcode);
			evt_q.status    <= abort_status;
			evt_q.retry     <= retry_count;
			evt_q.sel       <= counter_select;
			evt_q.in_range  <= in_range;
		end
	end

	assign mem_wr_en   = (state_q == ST_CLEAR) || (done && upd_wr);
	assign mem_wr_addr = (state_q == ST_CLEAR) ? clr_addr_q : addr_q;
	assign mem_wr_data = (state_q == ST_CLEAR) ? row_t'('0) : upd_row;

	tasc_counter_ram #(
		.DEPTH  (NUM_ROWS),
		.ADDR_W (ROW_W)
	) u_ram (
		.clk     (clk),
		.rd_en   (in_acc),
		.rd_addr (in_addr),
		.rd_data (rd_row),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	tasc_row_update u_update (
		.evt          (evt_q),
		.lock_code    (lock_code_q),
		.row_in       (rd_row),
		.row_out      (upd_row),
		.row_wr       (upd_wr),
		.read_value   (upd_value),
		.status_error (upd_err)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			read_value_q   <= upd_value;
			status_error_q <= upd_err;
		end
	end

	assign out_valid    = out_valid_q;
	assign read_value   = read_value_q;
	assign status_error = status_error_q;

	a_acc_to_update: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_UPDATE))
		else $error("accepted word did not move to update");

	a_wr_only_clear_or_update: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr_en |-> ((state_q == ST_CLEAR) || (state_q == ST_UPDATE)))
		else $error("counter memory written outside clear or update");

	a_done_emits: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (out_valid_q && (state_q == ST_IDLE)))
		else $error("completed update did not present a result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !done)
		else $error("pending result overwritten");

endmodule

// File: bench/tx_abort_stats_counters_core_tb.sv
// Self-checking bench for the abort statistics table: queued events, predicted counter reads.
`timescale 1ns / 1ps

module tx_abort_stats_counters_core_tb;
	import tasc_pkg::*;

	localparam int IDLE_LIMIT  = 4000;
	localparam int RAND_PHASES = 6;
	localparam int PHASE_WORDS = 312;

	typedef struct packed {
		op_t         op;
		logic [2:0]  th;
		logic [3:0]  tx;
		logic [31:0] status;
		logic [15:0] retry;
		logic [3:0]  sel;
	} event_word_t;

	typedef struct packed {
		logic [31:0] value;
		logic        err;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = 8'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  opcode = 2'd0;
	logic [2:0]  thread_id = 3'd0;
	logic [3:0]  transaction_id = 4'd0;
	logic [31:0] abort_status = 32'd0;
	logic [15:0] retry_count = 16'd0;
	logic [3:0]  counter_select = 4'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] read_value;
	logic        status_error;

	// predictor state
	logic [31:0] tally [8][16][NUM_COUNTERS];
	logic [7:0]  lock_code;

	event_word_t word_q [$];
	event_word_t cur_word;
	result_t     pending_results [$];
	int unsigned snd_idle_pct = 0;
	int unsigned rcv_stall_pct = 0;
	int unsigned mismatches = 0;
	int unsigned idle_cycles = 0;

	tx_abort_stats_counters_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.thread_id      (thread_id),
		.transaction_id (transaction_id),
		.abort_status   (abort_status),
		.retry_count    (retry_count),
		.counter_select (counter_select),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.read_value     (read_value),
		.status_error   (status_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	function automatic void bump(input logic [2:0] th, input logic [3:0] tx,
			input logic [SEL_W-1:0] k, input logic [31:0] amount);
		tally[th][tx][k] = tally[th][tx][k] + amount;
	endfunction

	// applies one event to the counter table and returns the result it gives
	function automatic result_t tally_event(input event_word_t w);
		result_t r;
		logic [31:0] st;
		r = '0;
		st = w.status;
		case (w.op)
			OP_ABORT: begin
				r.err = st[BIT_RETRY] && (st[BIT_DEBUG] || st[BIT_NESTED]);
				bump(w.th, w.tx, CNT_TOTAL, 1);
				if (st[BIT_EXPLICIT]) begin
					bump(w.th, w.tx, CNT_EXPLICIT, 1);
					if (st[CODE_LSB +: 8] == lock_code)
						bump(w.th, w.tx, CNT_LOCK_TAKEN, 1);
				end
				if (st[BIT_RETRY]) begin
					bump(w.th, w.tx, CNT_RETRY, 1);
					if (st[BIT_CONFLICT])
						bump(w.th, w.tx, CNT_RETRY_CONFL, 1);
					if (st[BIT_CAPACITY])
						bump(w.th, w.tx, CNT_RETRY_CAPAC, 1);
				end
				if (st[BIT_CONFLICT])
					bump(w.th, w.tx, CNT_CONFLICT, 1);
				if (st[BIT_CAPACITY])
					bump(w.th, w.tx, CNT_CAPACITY, 1);
				if (st[BIT_DEBUG])
					bump(w.th, w.tx, CNT_DEBUG, 1);
				if (st[BIT_NESTED])
					bump(w.th, w.tx, CNT_NESTED, 1);
				if (st == '0)
					bump(w.th, w.tx, CNT_ZERO_STATUS, 1);
			end
			OP_COMMIT: begin
				bump(w.th, w.tx, CNT_COMMITS, 1);
				bump(w.th, w.tx, CNT_COMMIT_RSUM, {16'd0, w.retry});
			end
			OP_FALLBACK: begin
				bump(w.th, w.tx, CNT_FALLBACKS, 1);
				bump(w.th, w.tx, CNT_FALLBK_RSUM, {16'd0, w.retry});
			end
			default: begin
				if (w.sel < NUM_COUNTERS)
					r.value = tally[w.th][w.tx][w.sel];
			end
		endcase
		return r;
	endfunction

	function automatic event_word_t mk_word(input op_t op, input logic [2:0] th,
			input logic [3:0] tx, input logic [31:0] st, input logic [15:0] rc,
			input logic [3:0] sel);
		event_word_t w;
		w.op = op;
		w.th = th;
		w.tx = tx;
		w.status = st;
		w.retry = rc;
		w.sel = sel;
		return w;
	endfunction

	function automatic event_word_t random_word();
		event_word_t w;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 35)
			w.op = OP_ABORT;
		else if (pick < 50)
			w.op = OP_COMMIT;
		else if (pick < 65)
			w.op = OP_FALLBACK;
		else
			w.op = OP_READ;
		// most traffic on a few hot entries so reads see built-up counts
		if ($urandom_range(3) != 0) begin
			w.th = 3'($urandom_range(1));
			w.tx = 4'($urandom_range(3));
		end else begin
			w.th = 3'($urandom);
			w.tx = 4'($urandom);
		end
		w.status = $urandom;
		case ($urandom_range(7))
			0: w.status = '0;
			1: w.status[23:6] = '0;
			2: w.status[31:24] = lock_code;
			3: begin
				w.status[31:24] = lock_code;
				w.status[BIT_EXPLICIT] = 1'b1;
			end
			default: ;
		endcase
		case ($urandom_range(9))
			0: w.retry = '0;
			1: w.retry = '1;
			default: w.retry = 16'($urandom);
		endcase
		w.sel = 4'($urandom_range(15));
		return w;
	endfunction

	// sender
	always @(posedge clk) begin : driver
		event_word_t w;
		if (arst_n) begin
			if (in_valid && !in_stall)
				pending_results.push_back(tally_event(cur_word));
			if (!(in_valid && in_stall)) begin
				if (word_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
					w = word_q.pop_front();
					cur_word = w;
					opcode <= w.op;
					thread_id <= w.th;
					transaction_id <= w.tx;
					abort_status <= w.status;
					retry_count <= w.retry;
					counter_select <= w.sel;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and result check
	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("word with no result pending", read_value, 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (read_value !== want.value)
					report_mismatch("read_value", read_value, want.value);
				if (status_error !== want.err)
					report_mismatch("status_error", {31'd0, status_error}, {31'd0, want.err});
			end
		end
		out_stall <= ($urandom_range(99) < rcv_stall_pct);
	end

	always @(posedge clk) begin : watchdog
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic wait_quiet();
		do
			@(negedge clk);
		while (word_q.size() != 0 || in_valid || pending_results.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_lock_code(input logic [7:0] code);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= code;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		lock_code = code;
	endtask

	initial begin : stimulus
		logic [7:0] code;
		int unsigned p;
		int unsigned i;
		int unsigned s;
		for (int t = 0; t < 8; t++)
			for (int x = 0; x < 16; x++)
				for (int k = 0; k < NUM_COUNTERS; k++)
					tally[t][x][k] = '0;
		lock_code = LOCK_CODE_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed words under the reset lock code
		snd_idle_pct = 29;
		rcv_stall_pct = 78;
		word_q.push_back(mk_word(OP_ABORT, 3'd7, 4'd15, 32'hFF00_0001, 16'd0, 4'd0));
		word_q.push_back(mk_word(OP_ABORT, 3'd7, 4'd15, 32'hFE00_0001, 16'd0, 4'd0));
		word_q.push_back(mk_word(OP_ABORT, 3'd7, 4'd15, 32'h0000_0000, 16'd0, 4'd0));
		word_q.push_back(mk_word(OP_ABORT, 3'd7, 4'd15, 32'hFFFF_FFFF, 16'hFFFF, 4'd15));
		word_q.push_back(mk_word(OP_ABORT, 3'd7, 4'd15, 32'h0000_0022, 16'd0, 4'd0));
		word_q.push_back(mk_word(OP_ABORT, 3'd7, 4'd15, 32'h0000_0012, 16'd0, 4'd0));
		word_q.push_back(mk_word(OP_ABORT, 3'd7, 4'd15, 32'h0000_000E, 16'd0, 4'd0));
		word_q.push_back(mk_word(OP_COMMIT, 3'd7, 4'd15, 32'd0, 16'hFFFF, 4'd0));
		word_q.push_back(mk_word(OP_COMMIT, 3'd0, 4'd0, 32'd0, 16'd0, 4'd0));
		word_q.push_back(mk_word(OP_FALLBACK, 3'd7, 4'd15, 32'd0, 16'hFFFF, 4'd0));
		for (s = 0; s < 16; s++)
			word_q.push_back(mk_word(OP_READ, 3'd7, 4'd15, 32'd0, 16'd0, 4'(s)));
		word_q.push_back(mk_word(OP_READ, 3'd0, 4'd0, 32'd0, 16'd0, CNT_COMMITS));
		wait_quiet();

		for (p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0, 4: code = 8'd0;
				1, 3: code = 8'd255;
				default: code = 8'($urandom);
			endcase
			write_lock_code(code);
			case (p / 2)
				0: begin
					snd_idle_pct = 29;
					rcv_stall_pct = 78;
				end
				1: begin
					snd_idle_pct = 78;
					rcv_stall_pct = 29;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_stall_pct = 0;
				end
			endcase
			for (i = 0; i < PHASE_WORDS; i++) begin
				// hold back mid-phase until the table has answered everything
				if (p == 3 && i == PHASE_WORDS / 2)
					wait_quiet();
				word_q.push_back(random_word());
			end
			wait_quiet();
		end

		if (mismatches == 0 && pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
